/* hw/rtl/miller_rabin_witness_test_top_macros.svh */
// Assertion macros for the witness test block.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef MILLER_RABIN_WITNESS_TEST_TOP_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define MRW_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("mrw assertion failed");

`define MRW_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("mrw assertion failed");

`else

`define MRW_ASSERT_SAME(lbl, pre, post)
`define MRW_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* hw/rtl/mrw_pkg.sv */
`default_nettype none

package mrw_pkg;

    localparam int FIELD_W   = 32;
    localparam int VERDICT_W = 2;

    typedef logic [VERDICT_W-1:0] t_verdict;

    localparam t_verdict VERDICT_PRIME   = 2'd0;
    localparam t_verdict VERDICT_ROOT    = 2'd1;
    localparam t_verdict VERDICT_FINAL   = 2'd2;
    localparam t_verdict VERDICT_INVALID = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/mrw_if.sv */
`default_nettype none

interface mrw_in_if;
    logic                         valid;
    logic                         ready;
    logic [mrw_pkg::FIELD_W-1:0]  candidate;
    logic [mrw_pkg::FIELD_W-1:0]  witness;

    modport source (output valid, output candidate, output witness, input ready);
    modport sink   (input valid, input candidate, input witness, output ready);
endinterface

interface mrw_out_if;
    logic                  valid;
    logic                  ready;
    mrw_pkg::t_verdict     verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

/* hw/rtl/miller_rabin_witness_test_top.sv */
// Channel   Dir  Word                      Accepted when
// i_in      in   candidate[31:0], witness  i_in.valid & i_in.ready
// o_res     out  verdict[1:0]              o_res.valid & o_res.ready
//
// One word at a time; i_in.ready is high only while no word is under test.
// Per word: the factors of two are stripped from n-1, then each of the WIDTH bits of d takes a
// square (skipped while x is one) and a multiply when the bit is set, then up to s-1 squarings;
// every mod-multiply runs bit-serially on the one modular adder. Invalid words go straight
// from the check to the finish state. Reset is synchronous and clears control state only.
// A verdict waits in the output register while the next word is accepted.
`default_nettype none
`include "miller_rabin_witness_test_top_macros.svh"

module miller_rabin_witness_test_top #(
    parameter int WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrw_in_if.sink     i_in,
    mrw_out_if.source  o_res
);

    localparam int BW = $clog2(WIDTH);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CHECK   = 8'b0000_0010,
        ST_STRIP   = 8'b0000_0100,
        ST_POW_SQ  = 8'b0000_1000,
        ST_POW_MUL = 8'b0001_0000,
        ST_TEST    = 8'b0010_0000,
        ST_SQ      = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [WIDTH-1:0]  r_n, n_n, r_a, n_a, r_nm1, n_nm1, r_d, n_d, r_x, n_x;
    logic [BW-1:0]     r_s, n_s, r_bit, n_bit;
    logic              r_wait, n_wait;
    mrw_pkg::t_verdict r_verdict, n_verdict, r_out_verdict, n_out_verdict;
    logic              r_out_valid, n_out_valid;

    logic [WIDTH-1:0]  w_cand, w_wit, w_mul_y, w_prod;
    logic              w_mul_start, w_mul_done, w_invalid, w_accept;

    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            if (i < mrw_pkg::FIELD_W) begin
                w_cand[i] = i_in.candidate[i % mrw_pkg::FIELD_W];
                w_wit[i]  = i_in.witness[i % mrw_pkg::FIELD_W];
            end else begin
                w_cand[i] = 1'b0;
                w_wit[i]  = 1'b0;
            end
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_invalid  = !r_n[0] || (r_n < WIDTH'(5)) || (r_a < WIDTH'(2))
                        || (r_a > (r_n - WIDTH'(2)));

    mrw_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (r_x),
        .i_y     (w_mul_y),
        .i_m     (r_n),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_a           = r_a;
        n_nm1         = r_nm1;
        n_d           = r_d;
        n_x           = r_x;
        n_s           = r_s;
        n_bit         = r_bit;
        n_wait        = r_wait;
        n_verdict     = r_verdict;
        n_out_verdict = r_out_verdict;
        n_out_valid   = (r_out_valid && o_res.ready) ? 1'b0 : r_out_valid;
        w_mul_start   = 1'b0;
        w_mul_y       = r_x;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_n     = w_cand;
                    n_a     = w_wit;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_invalid) begin
                    n_verdict = mrw_pkg::VERDICT_INVALID;
                    n_state   = ST_FINISH;
                end else begin
                    n_nm1   = r_n - WIDTH'(1);
                    n_d     = r_n - WIDTH'(1);
                    n_s     = '0;
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + BW'(1);
                end else begin
                    n_x     = WIDTH'(1);
                    n_bit   = BW'(WIDTH - 1);
                    n_state = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                if (r_wait) begin
                    if (w_mul_done) begin
                        n_x     = w_prod;
                        n_wait  = 1'b0;
                        n_state = ST_POW_MUL;
                    end
                end else if (r_x == WIDTH'(1)) begin
                    n_state = ST_POW_MUL;
                end else begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end
            end
            ST_POW_MUL: begin
                if (r_wait) begin
                    if (w_mul_done) begin
                        n_x    = w_prod;
                        n_wait = 1'b0;
                        if (r_bit == '0) begin
                            n_state = ST_TEST;
                        end else begin
                            n_bit   = r_bit - BW'(1);
                            n_state = ST_POW_SQ;
                        end
                    end
                end else if (r_d[r_bit]) begin
                    w_mul_y     = r_a;
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (r_bit == '0) begin
                    n_state = ST_TEST;
                end else begin
                    n_bit   = r_bit - BW'(1);
                    n_state = ST_POW_SQ;
                end
            end
            ST_TEST: begin
                if (r_x == WIDTH'(1) || r_x == r_nm1) begin
                    n_verdict = mrw_pkg::VERDICT_PRIME;
                    n_state   = ST_FINISH;
                end else if (r_s <= BW'(1)) begin
                    n_verdict = mrw_pkg::VERDICT_FINAL;
                    n_state   = ST_FINISH;
                end else begin
                    n_s     = r_s - BW'(1);
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                if (r_wait) begin
                    if (w_mul_done) begin
                        n_x    = w_prod;
                        n_wait = 1'b0;
                        if (w_prod == r_nm1) begin
                            n_verdict = mrw_pkg::VERDICT_PRIME;
                            n_state   = ST_FINISH;
                        end else if (w_prod == WIDTH'(1)) begin
                            n_verdict = mrw_pkg::VERDICT_ROOT;
                            n_state   = ST_FINISH;
                        end else if (r_s == BW'(1)) begin
                            n_verdict = mrw_pkg::VERDICT_FINAL;
                            n_state   = ST_FINISH;
                        end else begin
                            n_s = r_s - BW'(1);
                        end
                    end
                end else begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_verdict = r_verdict;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n           <= n_n;
        r_a           <= n_a;
        r_nm1         <= n_nm1;
        r_d           <= n_d;
        r_x           <= n_x;
        r_s           <= n_s;
        r_bit         <= n_bit;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.verdict = r_out_verdict;

    `MRW_ASSERT_NEXT(a_accept_check, w_accept, r_state == ST_CHECK)
    `MRW_ASSERT_SAME(a_load_from_finish, $rose(r_out_valid), $past(r_state) == ST_FINISH)
    `MRW_ASSERT_NEXT(a_invalid_verdict, (r_state == ST_CHECK) && w_invalid,
                     r_verdict == mrw_pkg::VERDICT_INVALID)
    `MRW_ASSERT_SAME(a_done_while_wait, w_mul_done, r_wait)

endmodule

`default_nettype wire

/* hw/rtl/mrw_modmul.sv */
`default_nettype none
`include "miller_rabin_witness_test_top_macros.svh"

module mrw_modmul #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_m,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_prod
);

    localparam int BW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_DBL  = 3'b010,
        MS_ADD  = 3'b100
    } t_mstate;

    t_mstate          r_state, n_state;
    logic [WIDTH-1:0] r_x, r_y, r_m, r_acc, n_acc;
    logic [BW-1:0]    r_idx, n_idx;
    logic             r_done, n_done;

    logic [WIDTH-1:0] w_q;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_red;
    logic [WIDTH-1:0] w_addmod;

    // shared modular adder: both operands below m
    always_comb begin
        w_q      = (r_state == MS_ADD) ? r_x : r_acc;
        w_sum    = {1'b0, r_acc} + {1'b0, w_q};
        w_red    = w_sum - {1'b0, r_m};
        w_addmod = (w_sum >= {1'b0, r_m}) ? w_red[WIDTH-1:0] : w_sum[WIDTH-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_done  = 1'b0;
        unique case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    n_acc   = '0;
                    n_idx   = BW'(WIDTH - 1);
                    n_state = MS_DBL;
                end
            end
            MS_DBL: begin
                n_acc = w_addmod;
                if (r_y[r_idx]) begin
                    n_state = MS_ADD;
                end else if (r_idx == '0) begin
                    n_done  = 1'b1;
                    n_state = MS_IDLE;
                end else begin
                    n_idx = r_idx - BW'(1);
                end
            end
            MS_ADD: begin
                n_acc = w_addmod;
                if (r_idx == '0) begin
                    n_done  = 1'b1;
                    n_state = MS_IDLE;
                end else begin
                    n_idx   = r_idx - BW'(1);
                    n_state = MS_DBL;
                end
            end
            default: n_state = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_idx <= n_idx;
        if (r_state == MS_IDLE && i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_m <= i_m;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `MRW_ASSERT_NEXT(a_start_dbl, (r_state == MS_IDLE) && i_start, r_state == MS_DBL)
    `MRW_ASSERT_SAME(a_done_last, r_done, $past(r_idx) == '0)
    `MRW_ASSERT_SAME(a_done_reduced, r_done, r_acc < r_m)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_WORDS    = 45;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrw_in_if  in_bus();
    mrw_out_if res_bus();

    miller_rabin_witness_test_top #(.WIDTH(mrw_pkg::FIELD_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_res   (res_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    mrw_pkg::t_verdict expected_verdicts[$];
    int       error_count   = 0;
    int       words_sent    = 0;
    int       verdicts_seen = 0;
    int       verdict_tally[4] = '{0, 0, 0, 0};
    int       src_idle_pct  = 0;
    int       snk_stall_pct = 0;
    int       holdoff_left  = 0;

    // Modular arithmetic over operands below 2^32, kept exact in 64 bits.
    function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] sum;
        sum = x + y;
        if (sum >= m) begin
            sum = sum - m;
        end
        return sum;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        for (int i = mrw_pkg::FIELD_W - 1; i >= 0; i--) begin
            acc = mod_add(acc, acc, m);
            if (y[i]) begin
                acc = mod_add(acc, x, m);
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = mrw_pkg::FIELD_W - 1; i >= 0; i--) begin
            acc = mod_mul(acc, acc, m);
            if (e[i]) begin
                acc = mod_mul(acc, base, m);
            end
        end
        return acc;
    endfunction

    function automatic mrw_pkg::t_verdict predict_verdict(logic [mrw_pkg::FIELD_W-1:0] cand,
                                                          logic [mrw_pkg::FIELD_W-1:0] wit);
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] n_minus_1;
        int          s;
        n = {32'd0, cand};
        a = {32'd0, wit};
        if (!n[0] || n < 64'd5) begin
            return mrw_pkg::VERDICT_INVALID;
        end
        if (a < 64'd2 || a > n - 64'd2) begin
            return mrw_pkg::VERDICT_INVALID;
        end
        n_minus_1 = n - 64'd1;
        d = n_minus_1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 64'd1 || x == n_minus_1) begin
            return mrw_pkg::VERDICT_PRIME;
        end
        for (int j = 1; j < s; j++) begin
            x = mod_mul(x, x, n);
            if (x == n_minus_1) begin
                return mrw_pkg::VERDICT_PRIME;
            end
            if (x == 64'd1) begin
                return mrw_pkg::VERDICT_ROOT;
            end
        end
        return mrw_pkg::VERDICT_FINAL;
    endfunction

    // Offer one word; returns at the rising edge that accepts it.
    task automatic send_word(logic [mrw_pkg::FIELD_W-1:0] cand,
                             logic [mrw_pkg::FIELD_W-1:0] wit);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid     = 1'b1;
        in_bus.candidate = cand;
        in_bus.witness   = wit;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        expected_verdicts.push_back(predict_verdict(cand, wit));
        words_sent++;
    endtask

    function automatic logic [mrw_pkg::FIELD_W-1:0] known_prime(int idx);
        case (idx)
            0:       return 32'd5;
            1:       return 32'd13;
            2:       return 32'd97;
            3:       return 32'd257;
            4:       return 32'd65537;
            5:       return 32'd1000000007;
            6:       return 32'd998244353;
            7:       return 32'd2147483647;
            8:       return 32'd3221225473;
            default: return 32'd4294967291;
        endcase
    endfunction

    function automatic logic [mrw_pkg::FIELD_W-1:0] known_pseudoprime(int idx);
        case (idx)
            0:       return 32'd561;
            1:       return 32'd1105;
            2:       return 32'd1729;
            3:       return 32'd2047;
            4:       return 32'd41041;
            5:       return 32'd1373653;
            6:       return 32'd25326001;
            default: return 32'd3215031751;
        endcase
    endfunction

    function automatic logic [mrw_pkg::FIELD_W-1:0] legal_witness(
        logic [mrw_pkg::FIELD_W-1:0] n);
        int pick;
        if (n < 5) begin
            return $urandom;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 32'd2;
        end
        if (pick == 1) begin
            return n - 32'd2;
        end
        return 32'd2 + ($urandom % (n - 32'd3));
    endfunction

    task automatic pick_random_word(output logic [mrw_pkg::FIELD_W-1:0] cand,
                                    output logic [mrw_pkg::FIELD_W-1:0] wit);
        int                          kind;
        int                          shift;
        logic [mrw_pkg::FIELD_W-1:0] k;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            cand = $urandom;
            wit  = $urandom;
        end else if (kind < 20) begin
            // broken words: even, tiny, or witness out of range
            cand = $urandom | 32'd1;
            wit  = legal_witness(cand);
            case ($urandom_range(0, 5))
                0:       cand = $urandom & ~32'd1;
                1:       cand = $urandom_range(0, 4);
                2:       wit  = 32'd0;
                3:       wit  = 32'd1;
                4:       wit  = cand - 32'd1;
                default: wit  = cand;
            endcase
        end else if (kind < 45) begin
            cand = $urandom | 32'd1;
            wit  = legal_witness(cand);
        end else if (kind < 65) begin
            cand = known_prime($urandom_range(0, 9));
            wit  = legal_witness(cand);
        end else if (kind < 80) begin
            cand = known_pseudoprime($urandom_range(0, 7));
            wit  = legal_witness(cand);
        end else begin
            // many factors of two in n-1: long squaring chains
            k     = $urandom | 32'd1;
            shift = $urandom_range(1, 31);
            cand  = (k << shift) | 32'd1;
            wit   = legal_witness(cand);
        end
    endtask

    task automatic test_invalid_words();
        send_word(32'd0, 32'd0);
        send_word(32'd1, 32'd2);
        send_word(32'd2, 32'd2);
        send_word(32'd3, 32'd2);
        send_word(32'd4, 32'd2);
        send_word(32'hFFFF_FFFE, 32'd3);
        send_word(32'd5, 32'd1);
        send_word(32'd5, 32'd4);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_edge_values();
        send_word(32'd5, 32'd2);
        send_word(32'd5, 32'd3);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFD);
        send_word(32'hFFFF_FFFF, 32'd2);
        send_word(32'd4294967291, 32'd2);
        send_word(32'd4294967291, 32'hFFFF_FFF9);
    endtask

    task automatic test_special_cases();
        send_word(32'd7, 32'd2);          // first power is one, s of one
        send_word(32'd7, 32'd3);          // first power is minus one
        send_word(32'd15, 32'd2);         // s of one, no squaring, composite
        send_word(32'd9, 32'd2);          // minus one never reached
        send_word(32'd561, 32'd2);        // nontrivial root of one
        send_word(32'd2047, 32'd2);       // strong pseudoprime to base two
        send_word(32'd3215031751, 32'd7);
        send_word(32'd3221225473, 32'd5); // long squaring chain
        send_word(32'd65537, 32'd3);
    endtask

    task automatic test_random_phase(int src_pct, int snk_pct);
        logic [mrw_pkg::FIELD_W-1:0] cand;
        logic [mrw_pkg::FIELD_W-1:0] wit;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < PHASE_WORDS; i++) begin
            pick_random_word(cand, wit);
            send_word(cand, wit);
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        holdoff_left  = HOLDOFF_CYCLES;
        for (int i = 0; i < 8; i++) begin
            if (i[0]) begin
                send_word($urandom & ~32'd1, $urandom);
            end else begin
                send_word(32'd9 + 32'(2 * i), 32'd2);
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                res_bus.ready = 1'b0;
                holdoff_left--;
            end else begin
                res_bus.ready = ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        mrw_pkg::t_verdict want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            verdicts_seen++;
            verdict_tally[res_bus.verdict]++;
            if (expected_verdicts.size() == 0) begin
                $error("verdict with no word outstanding: actual %0d", res_bus.verdict);
                error_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (res_bus.verdict !== want) begin
                    $error("verdict mismatch: expected %0d, actual %0d", want, res_bus.verdict);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $error("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL miller_rabin_witness_test_top");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.candidate = '0;
        in_bus.witness   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_invalid_words();
        test_edge_values();
        test_special_cases();
        test_random_phase(0, 0);
        test_random_phase(78, 0);
        test_random_phase(0, 78);
        test_random_phase(6, 6);
        test_backpressure();

        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", expected_verdicts.size());
            error_count++;
        end

        $display("Ran %0d words through invalid, edge, special, random and back-pressure tests",
                 words_sent);
        $display("Verdicts: %0d prime, %0d root, %0d final, %0d invalid; %0d errors",
                 verdict_tally[mrw_pkg::VERDICT_PRIME], verdict_tally[mrw_pkg::VERDICT_ROOT],
                 verdict_tally[mrw_pkg::VERDICT_FINAL],
                 verdict_tally[mrw_pkg::VERDICT_INVALID], error_count);
        if (error_count == 0) begin
            $display("PASS miller_rabin_witness_test_top");
        end else begin
            $display("FAIL miller_rabin_witness_test_top");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mrw_pkg.sv
hw/rtl/mrw_if.sv
hw/rtl/mrw_modmul.sv
hw/rtl/miller_rabin_witness_test_top.sv
tb/tb_top.sv
